// File: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers for the trade side classifier
package tsc_pkg;

    // fixed field widths
    localparam int IW      = 10;
    localparam int MASK_W  = 6;
    localparam int VAL_W   = 40;
    localparam int SVOL_W  = 41;
    localparam int KIND_W  = 3;
    localparam int NUM_KINDS = 6;
    localparam int LFSR_W  = 16;

    // tick kinds, in emission order
    localparam logic [KIND_W-1:0] KIND_BID    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ASK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TRADE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OI     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEMAND = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SUPPLY = 3'd5;

    // presence mask bit positions
    localparam int PM_LAST  = 0;
    localparam int PM_QUOTE = 1;
    localparam int PM_VOL   = 2;
    localparam int PM_OI    = 3;
    localparam int PM_TBID  = 4;
    localparam int PM_TASK  = 5;

    // tie-break generator
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // one classified row, ready to be played out as ticks
    typedef struct packed {
        logic [IW-1:0]                      instrument;
        logic [NUM_KINDS-1:0]               emit;
        logic [NUM_KINDS-1:0][VAL_W-1:0]    value;
        logic [SVOL_W-1:0]                  svol;
    } tick_entry_t;

    // clamp to the 40-bit tick value range
    function automatic logic [VAL_W-1:0] sat_val(input logic [63:0] v);
        return (|v[63:VAL_W]) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
    endfunction

endpackage

// File: rtl/tsc_row_if.sv
`timescale 1ns / 1ps
// quote row and tick channels
interface tsc_row_if #(
    parameter int PRICE_BITS  = 48,
    parameter int VOLUME_BITS = 40
);
    logic                   valid;
    logic                   ready;
    logic [9:0]             instrument;
    logic [5:0]             present_mask;
    logic [PRICE_BITS-1:0]  last_price;
    logic [PRICE_BITS-1:0]  bid_price;
    logic [PRICE_BITS-1:0]  ask_price;
    logic [VOLUME_BITS-1:0] cumulative_volume;
    logic [39:0]            open_contracts;
    logic [39:0]            total_bid;
    logic [39:0]            total_ask;

    modport source (
        output valid, instrument, present_mask, last_price, bid_price, ask_price,
               cumulative_volume, open_contracts, total_bid, total_ask,
        input  ready
    );
    modport sink (
        input  valid, instrument, present_mask, last_price, bid_price, ask_price,
               cumulative_volume, open_contracts, total_bid, total_ask,
        output ready
    );
endinterface

interface tsc_tick_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [9:0]  tick_instrument;
    logic [39:0] tick_value;
    logic [40:0] signed_volume;
    logic        last_of_row;

    modport source (
        output valid, kind, tick_instrument, tick_value, signed_volume, last_of_row,
        input  ready
    );
    modport sink (
        input  valid, kind, tick_instrument, tick_value, signed_volume, last_of_row,
        output ready
    );
endinterface

// File: rtl/tsc_front.sv
`timescale 1ns / 1ps
// front end: row intake, per-instrument store, volume differencing and side classification
module tsc_front
    import tsc_pkg::*;
#(
    parameter int INSTRUMENTS = 1024,
    parameter int PRICE_BITS  = 48,
    parameter int VOLUME_BITS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    tsc_row_if.sink     row,
    output tick_entry_t push_entry,
    output logic        push_valid,
    input  logic        push_ready
);

    localparam int IDX_W = $clog2(INSTRUMENTS);
    localparam int MW    = IW + 17;

    typedef struct packed {
        logic [VOLUME_BITS-1:0] cum;
        logic [PRICE_BITS-1:0]  trade;
        logic [PRICE_BITS-1:0]  bid;
        logic [PRICE_BITS-1:0]  ask;
    } store_t;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_PUSH  = 6'b100000
    } fstate_t;

    // five restoring compare-subtract steps of the index reduction
    function automatic logic [IW-1:0] mod_half(input logic [IW-1:0] r, input int base);
        logic [MW-1:0] acc;
        logic [MW-1:0] sub;
        acc = MW'(r);
        sub = '0;
        for (int k = 4; k >= 0; k--)
        begin
            sub = MW'(INSTRUMENTS) << (k + base);
            if (acc >= sub)
            begin
                acc = acc - sub;
            end
        end
        return acc[IW-1:0];
    endfunction

    fstate_t                state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg;
    logic [LFSR_W-1:0]      lfsr_reg, lfsr_next;

    // row payload
    logic [IW-1:0]          inst_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [PRICE_BITS-1:0]  last_reg, bid_reg, ask_reg;
    logic [VOLUME_BITS-1:0] cum_reg;
    logic [VAL_W-1:0]       oi_reg, tb_reg, ta_reg;
    logic [IW-1:0]          modp_reg;
    logic [IDX_W-1:0]       idx_reg;
    store_t                 rd_reg;

    // compare results
    logic                   eq_bid_reg, eq_ask_reg, le_pbid_reg, ge_pask_reg;
    logic                   eq_ptr_reg, gt_ptr_reg, vol_nz_reg;
    logic [VAL_W-1:0]       vol_reg;

    store_t                 mem [INSTRUMENTS];
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    store_t                 mem_wdata;
    store_t                 new_store;

    logic                   row_fire, push_fire, quote, tie, buy, has_tick;
    logic [VOLUME_BITS-1:0] vol_full;
    logic [IW+16:0]         idx_ext;
    logic [SVOL_W-1:0]      vol_ext;

    assign row.ready = (state_reg == ST_IDLE);
    assign row_fire  = row.valid && row.ready;
    assign idx_ext   = (IW + 17)'(mod_half(modp_reg, 0));

    // volume differencing, a drop or an untouched store counts as first sight
    assign vol_full = ((cum_reg < rd_reg.cum) || (rd_reg.cum == '0)) ? '0 : cum_reg - rd_reg.cum;

    // quote rule, then tick rule, then random tie break; without quotes the trade is a buy
    assign quote = mask_reg[PM_LAST] && mask_reg[PM_QUOTE];
    assign tie   = quote && !eq_bid_reg && !eq_ask_reg && !le_pbid_reg && !ge_pask_reg
                   && eq_ptr_reg;

    always_comb
    begin
        if (!mask_reg[PM_QUOTE])
            buy = 1'b1;
        else if (eq_bid_reg)
            buy = 1'b0;
        else if (eq_ask_reg)
            buy = 1'b1;
        else if (le_pbid_reg)
            buy = 1'b0;
        else if (ge_pask_reg)
            buy = 1'b1;
        else if (eq_ptr_reg)
            buy = !lfsr_reg[0];
        else
            buy = gt_ptr_reg;
    end

    // classified row for the back end
    assign vol_ext = {1'b0, vol_reg};
    always_comb
    begin
        push_entry.instrument          = inst_reg;
        push_entry.emit[KIND_BID]      = quote;
        push_entry.emit[KIND_ASK]      = quote;
        push_entry.emit[KIND_TRADE]    = mask_reg[PM_LAST] && vol_nz_reg;
        push_entry.emit[KIND_OI]       = mask_reg[PM_OI];
        push_entry.emit[KIND_DEMAND]   = mask_reg[PM_TBID];
        push_entry.emit[KIND_SUPPLY]   = mask_reg[PM_TASK];
        push_entry.value[KIND_BID]     = sat_val(64'(bid_reg));
        push_entry.value[KIND_ASK]     = sat_val(64'(ask_reg));
        push_entry.value[KIND_TRADE]   = sat_val(64'(last_reg));
        push_entry.value[KIND_OI]      = oi_reg;
        push_entry.value[KIND_DEMAND]  = tb_reg;
        push_entry.value[KIND_SUPPLY]  = ta_reg;
        push_entry.svol                = buy ? vol_ext : (SVOL_W'(0) - vol_ext);
    end

    assign has_tick   = |push_entry.emit;
    assign push_valid = (state_reg == ST_PUSH) && has_tick;
    assign push_fire  = (state_reg == ST_PUSH) && (!has_tick || push_ready);

    // write-back of the store entry
    always_comb
    begin
        new_store.cum   = mask_reg[PM_VOL] ? cum_reg : rd_reg.cum;
        new_store.trade = quote ? last_reg : rd_reg.trade;
        new_store.bid   = quote ? bid_reg : rd_reg.bid;
        new_store.ask   = quote ? ask_reg : rd_reg.ask;
    end

    assign mem_we    = (state_reg == ST_CLEAR) || push_fire;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : new_store;

    // per-instrument store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(INSTRUMENTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (row_fire)
                    state_next = ST_MOD;
            end
            ST_MOD:  state_next = ST_READ;
            ST_READ: state_next = ST_CMP;
            ST_CMP:  state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (push_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // tie-break generator steps only on a tie
    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (push_fire && tie)
        begin
            lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            lfsr_reg    <= LFSR_SEED;
        end
        else
        begin
            state_reg <= state_next;
            lfsr_reg  <= lfsr_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // row capture, index reduction and compares
    always_ff @(posedge clk)
    begin
        if (row_fire)
        begin
            inst_reg <= row.instrument;
            mask_reg <= row.present_mask;
            last_reg <= row.last_price;
            bid_reg  <= row.bid_price;
            ask_reg  <= row.ask_price;
            cum_reg  <= row.cumulative_volume;
            oi_reg   <= row.open_contracts;
            tb_reg   <= row.total_bid;
            ta_reg   <= row.total_ask;
            modp_reg <= mod_half(row.instrument, 5);
        end
        if (state_reg == ST_MOD)
        begin
            idx_reg <= idx_ext[IDX_W-1:0];
        end
        if (state_reg == ST_CMP)
        begin
            eq_bid_reg  <= (last_reg == bid_reg);
            eq_ask_reg  <= (last_reg == ask_reg);
            le_pbid_reg <= (last_reg <= rd_reg.bid);
            ge_pask_reg <= (last_reg >= rd_reg.ask);
            eq_ptr_reg  <= (last_reg == rd_reg.trade);
            gt_ptr_reg  <= (last_reg > rd_reg.trade);
            vol_nz_reg  <= mask_reg[PM_VOL] && (|vol_full);
            vol_reg     <= sat_val(64'(vol_full));
        end
    end

endmodule

// File: rtl/tsc_queue.sv
`timescale 1ns / 1ps
// short queue of classified rows between front and back
module tsc_queue
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tick_entry_t in_entry,
    input  logic        in_valid,
    output logic        in_ready,
    output tick_entry_t out_entry,
    output logic        out_valid,
    input  logic        out_ready
);

    tick_entry_t         entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                wr, rd;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = entries_reg[rptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entries_reg[wptr_reg] <= in_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd)
                rptr_reg <= rptr_reg + 1'b1;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/tsc_back.sv
`timescale 1ns / 1ps
// back end: plays out a classified row as ticks, one word per cycle while the tick sink is ready
module tsc_back
    import tsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tick_entry_t pop_entry,
    input  logic        pop_valid,
    output logic        pop_ready,
    tsc_tick_if.source  tick
);

    logic                 busy_reg;
    logic [NUM_KINDS-1:0] pend_reg;
    tick_entry_t          ent_reg;

    logic                 out_valid_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [IW-1:0]        inst_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [SVOL_W-1:0]    svol_reg;
    logic                 last_reg;

    logic [NUM_KINDS-1:0] low, pend_left;
    logic [KIND_W-1:0]    sel_kind;
    logic [VAL_W-1:0]     sel_val;
    logic                 out_free, emit_now, pop_fire;

    assign out_free  = !out_valid_reg || tick.ready;
    assign emit_now  = busy_reg && out_free;
    assign pop_ready = !busy_reg;
    assign pop_fire  = pop_valid && pop_ready;

    // lowest pending kind goes next
    assign low       = pend_reg & (~pend_reg + 1'b1);
    assign pend_left = pend_reg & ~low;

    always_comb
    begin
        sel_kind = KIND_BID;
        sel_val  = '0;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            if (low[k])
            begin
                sel_kind = KIND_W'(k);
                sel_val  = ent_reg.value[k];
            end
        end
    end

    assign tick.valid           = out_valid_reg;
    assign tick.kind            = kind_reg;
    assign tick.tick_instrument = inst_reg;
    assign tick.tick_value      = value_reg;
    assign tick.signed_volume   = svol_reg;
    assign tick.last_of_row     = last_reg;

    // row and output word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_fire)
            begin
                busy_reg <= 1'b1;
                pend_reg <= pop_entry.emit;
            end
            else if (emit_now)
            begin
                pend_reg <= pend_left;
                if (pend_left == '0)
                    busy_reg <= 1'b0;
            end
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (tick.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // row and output word payload
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            ent_reg <= pop_entry;
        end
        if (emit_now)
        begin
            kind_reg  <= sel_kind;
            inst_reg  <= ent_reg.instrument;
            value_reg <= sel_val;
            svol_reg  <= low[KIND_TRADE] ? ent_reg.svol : '0;
            last_reg  <= (pend_left == '0);
        end
    end

endmodule

// File: rtl/trade_side_classifier_top.sv
`timescale 1ns / 1ps
// top level of the trade side classifier
// Each accepted quote row passes through the front-end steps of accept, index
// reduction, store read, compare, write-back and hand-off, and no new row is taken
// until it has been handed off; the back end then loads the row and plays it out at
// one tick per cycle while the tick sink is ready. Sustained throughput is set by
// the single-port store read-modify-write in front and the tick output register in
// back. A two-entry queue lets either side stall alone.
// After reset the per-instrument store is zeroed one entry per cycle, all
// INSTRUMENTS entries, before the first row is taken.
module trade_side_classifier_top
    import tsc_pkg::*;
#(
    parameter int INSTRUMENTS = 1024,
    parameter int PRICE_BITS  = 48,
    parameter int VOLUME_BITS = 40
) (
    input  logic      clk,
    input  logic      rst_n,
    tsc_row_if.sink   row,
    tsc_tick_if.source tick
);

    tick_entry_t push_entry, pop_entry;
    logic        push_valid, push_ready, pop_valid, pop_ready;

    // row intake and classification
    tsc_front #(
        .INSTRUMENTS (INSTRUMENTS),
        .PRICE_BITS  (PRICE_BITS),
        .VOLUME_BITS (VOLUME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .row        (row),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // decoupling queue
    tsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (push_entry),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .out_entry (pop_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready)
    );

    // tick playout
    tsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .tick      (tick)
    );

    // front takes one row at a time
    a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
        row.valid && row.ready |=> !row.ready)
        else $error("row accepted while previous row still in front end");

    // only trade ticks carry volume
    a_svol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.kind != KIND_TRADE |-> tick.signed_volume == '0)
        else $error("volume on a non-trade tick");

    // a trade tick is emitted only with nonzero volume
    a_trade_vol: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.kind == KIND_TRADE |-> tick.signed_volume != '0)
        else $error("trade tick with zero volume");

    // kinds inside a row rise strictly until the last word
    a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready && !tick.last_of_row ##1 tick.valid
        |-> tick.kind > $past(tick.kind))
        else $error("tick kinds out of order within a row");

endmodule

// File: bench/trade_side_classifier_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the trade side classifier: directed rows, then random rows
module trade_side_classifier_top_tb
    import tsc_pkg::*;
();

    localparam int PB = 48;
    localparam int VB = 40;
    localparam int ROWS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES = 40;
    localparam int PREDICTED = -1;

    // per-phase idling, percent of cycles
    localparam int SEND_IDLE [4] = '{0, 79, 0, 17};
    localparam int RECV_STALL[4] = '{0, 0, 79, 17};

    // presence mask bits
    localparam logic [MASK_W-1:0] M_LAST  = 6'b1 << PM_LAST;
    localparam logic [MASK_W-1:0] M_QUOTE = 6'b1 << PM_QUOTE;
    localparam logic [MASK_W-1:0] M_VOL   = 6'b1 << PM_VOL;
    localparam logic [MASK_W-1:0] M_OI    = 6'b1 << PM_OI;
    localparam logic [MASK_W-1:0] M_TBID  = 6'b1 << PM_TBID;
    localparam logic [MASK_W-1:0] M_TASK  = 6'b1 << PM_TASK;
    localparam logic [MASK_W-1:0] M_TRADE_ROW = M_LAST | M_QUOTE | M_VOL;

    localparam logic [PB-1:0] PMAX = {PB{1'b1}};
    localparam logic [VB-1:0] VMAX = {VB{1'b1}};

    typedef struct packed {
        logic [IW-1:0]     instrument;
        logic [MASK_W-1:0] present_mask;
        logic [PB-1:0]     last_price;
        logic [PB-1:0]     bid_price;
        logic [PB-1:0]     ask_price;
        logic [VB-1:0]     cumulative_volume;
        logic [VAL_W-1:0]  open_contracts;
        logic [VAL_W-1:0]  total_bid;
        logic [VAL_W-1:0]  total_ask;
    } row_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IW-1:0]     tick_instrument;
        logic [VAL_W-1:0]  tick_value;
        logic [SVOL_W-1:0] signed_volume;
        logic              last_of_row;
    } tick_t;

    typedef tick_t [0:2] tick_trio_t;

    typedef struct {
        row_t       r;
        int         n_typed;
        tick_trio_t typed;
    } dir_entry_t;

    localparam tick_t NO_TICK = '0;

    logic clk = 1'b0;
    logic rst_n;

    tsc_row_if #(.PRICE_BITS(PB), .VOLUME_BITS(VB)) row_ch ();
    tsc_tick_if tick_ch ();

    trade_side_classifier_top #(
        .INSTRUMENTS(1024),
        .PRICE_BITS (PB),
        .VOLUME_BITS(VB)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .row  (row_ch),
        .tick (tick_ch)
    );

    // classifier state mirror
    logic [VB-1:0]     prior_cum  [1024];
    logic [PB-1:0]     prior_trade[1024];
    logic [PB-1:0]     prior_bid  [1024];
    logic [PB-1:0]     prior_ask  [1024];
    logic [LFSR_W-1:0] tie_lfsr;

    tick_t      pending_ticks[$];
    dir_entry_t dir_tab[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic row_t mk(input logic [IW-1:0] inst, input logic [MASK_W-1:0] mask,
                                input logic [PB-1:0] lst, input logic [PB-1:0] bid,
                                input logic [PB-1:0] ask, input logic [VB-1:0] cum,
                                input logic [VAL_W-1:0] oi, input logic [VAL_W-1:0] tb,
                                input logic [VAL_W-1:0] ta);
        return '{inst, mask, lst, bid, ask, cum, oi, tb, ta};
    endfunction

    function automatic tick_t tk(input logic [KIND_W-1:0] kind, input logic [IW-1:0] inst,
                                 input logic [VAL_W-1:0] value,
                                 input logic [SVOL_W-1:0] svol, input logic lst);
        return '{kind, inst, value, svol, lst};
    endfunction

    function automatic void add_dir(input row_t r, input int n, input tick_t a,
                                    input tick_t b, input tick_t c);
        dir_entry_t e;
        e.r = r;
        e.n_typed = n;
        e.typed[0] = a;
        e.typed[1] = b;
        e.typed[2] = c;
        dir_tab.insert(dir_tab.size(), e);
    endfunction

    // prices clamp at the tick value width
    function automatic logic [VAL_W-1:0] clamp_price(input logic [PB-1:0] p);
        return (|p[PB-1:VAL_W]) ? {VAL_W{1'b1}} : p[VAL_W-1:0];
    endfunction

    // galois step; the bit shifted out breaks the tie
    function automatic logic tie_step();
        logic b;
        b = tie_lfsr[0];
        tie_lfsr = tie_lfsr >> 1;
        if (b)
            tie_lfsr = tie_lfsr ^ LFSR_TAPS;
        return b;
    endfunction

    // ticks a row produces, updating the mirrored store
    function automatic void classify_row(input row_t r, output tick_t ticks[$]);
        logic [IW-1:0]     ix;
        logic [VB-1:0]     prev;
        logic [VB-1:0]     vol;
        logic [SVOL_W-1:0] mag;
        logic              buy;
        ticks = {};
        ix = r.instrument;
        vol = '0;
        buy = 1'b1;

        // volume differencing, drop or zero store means first sight
        if (r.present_mask[PM_VOL])
        begin
            prev = prior_cum[ix];
            if (r.cumulative_volume < prev)
                prev = '0;
            vol = (prev == 0) ? '0 : r.cumulative_volume - prev;
            prior_cum[ix] = r.cumulative_volume;
        end

        if (r.present_mask[PM_LAST])
        begin
            // quote rule, then tick rule, then tie break
            if (r.present_mask[PM_QUOTE])
            begin
                if (r.last_price == r.bid_price)
                    buy = 1'b0;
                else if (r.last_price == r.ask_price)
                    buy = 1'b1;
                else if (r.last_price <= prior_bid[ix])
                    buy = 1'b0;
                else if (r.last_price >= prior_ask[ix])
                    buy = 1'b1;
                else if (r.last_price == prior_trade[ix])
                    buy = !tie_step();
                else
                    buy = r.last_price > prior_trade[ix];
                prior_trade[ix] = r.last_price;
                prior_bid[ix] = r.bid_price;
                prior_ask[ix] = r.ask_price;
                ticks.insert(ticks.size(),
                             tk(KIND_BID, r.instrument, clamp_price(r.bid_price), '0, 1'b0));
                ticks.insert(ticks.size(),
                             tk(KIND_ASK, r.instrument, clamp_price(r.ask_price), '0, 1'b0));
            end
            if (vol != 0)
            begin
                mag = {1'b0, vol};
                ticks.insert(ticks.size(),
                             tk(KIND_TRADE, r.instrument, clamp_price(r.last_price),
                                buy ? mag : ('0 - mag), 1'b0));
            end
        end

        if (r.present_mask[PM_OI])
            ticks.insert(ticks.size(), tk(KIND_OI, r.instrument, r.open_contracts, '0, 1'b0));
        if (r.present_mask[PM_TBID])
            ticks.insert(ticks.size(), tk(KIND_DEMAND, r.instrument, r.total_bid, '0, 1'b0));
        if (r.present_mask[PM_TASK])
            ticks.insert(ticks.size(), tk(KIND_SUPPLY, r.instrument, r.total_ask, '0, 1'b0));
        if (ticks.size() > 0)
            ticks[ticks.size() - 1].last_of_row = 1'b1;
    endfunction

    // drive one row, wait for the handshake, record what it should produce
    task automatic send_row(input row_t r, input int n_typed, input tick_trio_t typed);
        tick_t calc[$];
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            row_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_ch.valid             <= 1'b1;
        row_ch.instrument        <= r.instrument;
        row_ch.present_mask      <= r.present_mask;
        row_ch.last_price        <= r.last_price;
        row_ch.bid_price         <= r.bid_price;
        row_ch.ask_price         <= r.ask_price;
        row_ch.cumulative_volume <= r.cumulative_volume;
        row_ch.open_contracts    <= r.open_contracts;
        row_ch.total_bid         <= r.total_bid;
        row_ch.total_ask         <= r.total_ask;
        @(posedge clk);
        while (!row_ch.ready)
            @(posedge clk);
        classify_row(r, calc);
        if (n_typed == PREDICTED)
            foreach (calc[i])
                pending_ticks.insert(pending_ticks.size(), calc[i]);
        else
            for (int i = 0; i < n_typed; i++)
                pending_ticks.insert(pending_ticks.size(), typed[i]);
        @(negedge clk);
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: tick %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
    endtask

    // tick sink back-pressure
    always @(negedge clk)
        tick_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // compare each accepted word against the oldest expectation
    always @(posedge clk)
    begin : tick_check
        tick_t got;
        tick_t want;
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            got = '{tick_ch.kind, tick_ch.tick_instrument, tick_ch.tick_value,
                    tick_ch.signed_volume, tick_ch.last_of_row};
            if (pending_ticks.size() == 0)
            begin
                $display("%0t: unexpected tick, expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (got.kind !== want.kind)
                    report_field("kind", want.kind, got.kind);
                if (got.tick_instrument !== want.tick_instrument)
                    report_field("tick_instrument", want.tick_instrument, got.tick_instrument);
                if (got.tick_value !== want.tick_value)
                    report_field("tick_value", want.tick_value, got.tick_value);
                if (got.signed_volume !== want.signed_volume)
                    report_field("signed_volume", want.signed_volume, got.signed_volume);
                if (got.last_of_row !== want.last_of_row)
                    report_field("last_of_row", want.last_of_row, got.last_of_row);
            end
        end
    end

    initial
    begin : stimulus
        row_t          r;
        logic [IW-1:0] pool_inst[8];
        logic [PB-1:0] pool_mid [8];
        logic [PB-1:0] pool_last[8];
        logic [VB-1:0] pool_cum [8];
        int            k;
        int            spread;

        rst_n = 1'b0;
        row_ch.valid = 1'b0;
        row_ch.instrument = '0;
        row_ch.present_mask = '0;
        row_ch.last_price = '0;
        row_ch.bid_price = '0;
        row_ch.ask_price = '0;
        row_ch.cumulative_volume = '0;
        row_ch.open_contracts = '0;
        row_ch.total_bid = '0;
        row_ch.total_ask = '0;

        // store is cleared by reset
        for (int i = 0; i < 1024; i++)
        begin
            prior_cum[i] = '0;
            prior_trade[i] = '0;
            prior_bid[i] = '0;
            prior_ask[i] = '0;
        end
        tie_lfsr = LFSR_SEED;

        // empty row, even with every value at its top
        add_dir(mk(0, '0, PMAX, PMAX, PMAX, VMAX, VMAX, VMAX, VMAX), 0,
                NO_TICK, NO_TICK, NO_TICK);
        // depth and interest only, value extremes
        add_dir(mk(1023, M_OI | M_TBID | M_TASK, 0, 0, 0, 0, VMAX, 0, VMAX), 3,
                tk(KIND_OI, 1023, VMAX, '0, 1'b0), tk(KIND_DEMAND, 1023, 0, '0, 1'b0),
                tk(KIND_SUPPLY, 1023, VMAX, '0, 1'b1));
        // first sight of an instrument: quotes but no trade volume
        add_dir(mk(5, M_TRADE_ROW, 100, 99, 101, 1000, 0, 0, 0), 2,
                tk(KIND_BID, 5, 99, '0, 1'b0), tk(KIND_ASK, 5, 101, '0, 1'b1), NO_TICK);
        // at ask, at bid, below prior bid, above prior ask
        add_dir(mk(5, M_TRADE_ROW, 101, 99, 101, 1500, 0, 0, 0), PREDICTED, '0, '0, '0);
        add_dir(mk(5, M_TRADE_ROW, 99, 99, 101, 1600, 0, 0, 0), PREDICTED, '0, '0, '0);
        add_dir(mk(5, M_TRADE_ROW, 98, 97, 100, 1700, 0, 0, 0), PREDICTED, '0, '0, '0);
        add_dir(mk(5, M_TRADE_ROW, 102, 99, 103, 1800, 0, 0, 0), PREDICTED, '0, '0, '0);
        // exact ties against prior trade
        add_dir(mk(5, M_TRADE_ROW, 102, 100, 104, 1900, 0, 0, 0), PREDICTED, '0, '0, '0);
        add_dir(mk(5, M_TRADE_ROW, 102, 98, 106, 2000, 0, 0, 0), PREDICTED, '0, '0, '0);
        // tick rule up then down
        add_dir(mk(5, M_TRADE_ROW, 104, 100, 105, 2100, 0, 0, 0), PREDICTED, '0, '0, '0);
        add_dir(mk(5, M_TRADE_ROW, 103, 99, 107, 2200, 0, 0, 0), PREDICTED, '0, '0, '0);
        // volume drop restarts the count
        add_dir(mk(5, M_TRADE_ROW, 103, 99, 107, 50, 0, 0, 0), PREDICTED, '0, '0, '0);
        // volume absent
        add_dir(mk(5, M_LAST | M_QUOTE, 104, 99, 107, 9999, 0, 0, 0), PREDICTED, '0, '0, '0);
        // last absent: nothing out, only volume store moves
        add_dir(mk(5, M_QUOTE | M_VOL, 0, 1, 2, 60, 0, 0, 0), 0, NO_TICK, NO_TICK, NO_TICK);
        // quotes absent: trade counts as a buy
        add_dir(mk(5, M_LAST | M_VOL, 1, 0, 0, 70, 0, 0, 0), PREDICTED, '0, '0, '0);
        // untouched price store, zero prior ask
        add_dir(mk(7, M_VOL, 0, 0, 0, 500, 0, 0, 0), 0, NO_TICK, NO_TICK, NO_TICK);
        add_dir(mk(7, M_TRADE_ROW, 50, 40, 60, 800, 0, 0, 0), PREDICTED, '0, '0, '0);
        // wide prices saturate, largest buy volume
        add_dir(mk(1023, M_TRADE_ROW, PMAX, PMAX - 1, PMAX, 1, 0, 0, 0), 2,
                tk(KIND_BID, 1023, VMAX, '0, 1'b0), tk(KIND_ASK, 1023, VMAX, '0, 1'b1),
                NO_TICK);
        add_dir(mk(1023, M_TRADE_ROW, PMAX, PMAX - 1, PMAX, VMAX, 0, 0, 0), PREDICTED,
                '0, '0, '0);
        // largest sell volume at zero price
        add_dir(mk(0, M_VOL, 0, 0, 0, 1, 0, 0, 0), 0, NO_TICK, NO_TICK, NO_TICK);
        add_dir(mk(0, M_TRADE_ROW, 0, 0, 1, VMAX, 0, 0, 0), PREDICTED, '0, '0, '0);
        // every kind in one row
        add_dir(mk(7, '1, 55, 54, 56, 900, 11, 22, 33), PREDICTED, '0, '0, '0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_row(dir_tab[i].r, dir_tab[i].n_typed, dir_tab[i].typed);

        // random pool of active instruments around a wandering mid
        for (int i = 0; i < 8; i++)
        begin
            pool_inst[i] = (i == 0) ? 10'd0 : (i == 1) ? 10'd1023 : 10'($urandom);
            pool_mid[i] = {16'($urandom_range(1, 65534)), 32'($urandom)};
            pool_last[i] = pool_mid[i];
            pool_cum[i] = 40'($urandom_range(1, 1000));
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            // hold off until the block has drained
            row_ch.valid <= 1'b0;
            while (pending_ticks.size() != 0)
                @(negedge clk);
            repeat (20) @(negedge clk);
            send_idle_pct = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];

            for (int n = 0; n < ROWS_PER_PHASE; n++)
            begin
                k = $urandom_range(0, 7);
                r.open_contracts = 40'({$urandom, $urandom});
                r.total_bid = 40'({$urandom, $urandom});
                r.total_ask = 40'({$urandom, $urandom});
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise row
                    r.instrument = 10'($urandom);
                    r.present_mask = 6'($urandom);
                    r.last_price = 48'({$urandom, $urandom});
                    r.bid_price = 48'({$urandom, $urandom});
                    r.ask_price = 48'({$urandom, $urandom});
                    r.cumulative_volume = 40'({$urandom, $urandom});
                end
                else
                begin
                    // well-formed quote row on a pool instrument
                    pool_mid[k] = pool_mid[k] + 48'($urandom_range(0, 6)) - 48'd3;
                    spread = $urandom_range(1, 8);
                    r.instrument = pool_inst[k];
                    r.present_mask = ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                                 : {3'($urandom), 3'b111};
                    r.bid_price = pool_mid[k] - 48'(spread);
                    r.ask_price = pool_mid[k] + 48'(spread);
                    case ($urandom_range(0, 5))
                        0: r.last_price = r.bid_price;
                        1: r.last_price = r.ask_price;
                        2, 3: r.last_price = pool_last[k];
                        4: r.last_price = pool_mid[k];
                        default: r.last_price = r.bid_price - 48'd2
                                                + 48'($urandom_range(0, 2 * spread + 4));
                    endcase
                    pool_last[k] = r.last_price;
                    case ($urandom_range(0, 19))
                        0: pool_cum[k] = 40'($urandom_range(0, 50));
                        1: pool_cum[k] = 40'({$urandom, $urandom});
                        default: pool_cum[k] = pool_cum[k] + 40'($urandom_range(0, 500));
                    endcase
                    r.cumulative_volume = pool_cum[k];
                end
                send_row(r, PREDICTED, '0);
            end
        end

        // drain, then watch for stray ticks
        row_ch.valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("trade_side_classifier_top_tb: PASS");
        else
            $display("trade_side_classifier_top_tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("trade_side_classifier_top_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/tsc_pkg.sv
rtl/tsc_row_if.sv
rtl/tsc_front.sv
rtl/tsc_queue.sv
rtl/tsc_back.sv
rtl/trade_side_classifier_top.sv
bench/trade_side_classifier_top_tb.sv
